@@ hw/rtl/set_assoc_lru_read_cache_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU read cache
// Shared concurrent-assertion forms, sampled on the rising clock edge and
// disabled while the synchronous reset is active.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_READ_CACHE_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_READ_CACHE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SALA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SALA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sala_pkg.sv @@
// ----------------------------------------------------------------------------
// sala_pkg
// Types and fixed constants shared by the set-associative LRU read cache.
// ----------------------------------------------------------------------------
package sala_pkg;

  localparam int ADDR_W  = 32;
  localparam int DEST_W  = 3;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int LOW_W   = 64;
  localparam int MID_W   = 64;
  localparam int HIGH_W  = 32;
  localparam int LINE_W  = LOW_W + MID_W + HIGH_W;

  typedef enum logic {
    REQ_READ = 1'b0,
    REQ_FILL = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    OUT_HIT  = 2'd0,
    OUT_MISS = 2'd1,
    OUT_DONE = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_LINE,
    ST_SCAN,
    ST_FILL
  } core_state_t;

  // Request as held for the whole transaction
  typedef struct packed {
    req_type_t             req_type;
    logic [DEST_W-1:0]     dest;
    logic [HIGH_W-1:0]     fill_high;
    logic [MID_W-1:0]      fill_mid;
    logic [LOW_W-1:0]      fill_low;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    outcome_t              outcome;
    logic [DEST_W-1:0]     dest;
    logic [HIGH_W-1:0]     line_high;
    logic [MID_W-1:0]      line_mid;
    logic [LOW_W-1:0]      line_low;
    logic                  idle;
    logic [CNT_W-1:0]      access_total;
    logic [CNT_W-1:0]      hit_total;
  } result_t;

endpackage

@@ hw/rtl/sala_cdiv.sv @@
// ----------------------------------------------------------------------------
// sala_cdiv
// Two-stage divider by a constant: reciprocal multiply, then one
// compare-and-subtract correction that also yields the remainder.
// ----------------------------------------------------------------------------
module sala_cdiv #(
  parameter int IN_W    = 32,
  parameter int DIVISOR = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic [IN_W-1:0]      dividend_i,
  output logic                 valid_o,
  output logic [IN_W-1:0]      quot_o,
  output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] rem_o
);

  localparam int K     = $clog2(DIVISOR);
  localparam int RW    = (DIVISOR > 1) ? K : 1;
  localparam int S     = IN_W + K;
  localparam int PW    = S + 1;
  localparam int PRW   = 2 * IN_W + 1;
  localparam int EW    = ((IN_W > K + 1) ? IN_W : K + 1) + 1;
  localparam logic [PW-1:0]   POW        = PW'(1) << S;
  localparam logic [PW-1:0]   RECIP_FULL = POW / PW'(DIVISOR);
  localparam logic [IN_W:0]   RECIP      = RECIP_FULL[IN_W:0];
  localparam logic [EW-1:0]   DIV_E      = EW'(DIVISOR);

  logic            v1_r, v2_r;
  logic [IN_W-1:0] x_r, q0_r, quot_r;
  logic [RW-1:0]   rem_r;
  logic [PRW-1:0]  prod;
  logic [EW-1:0]   qd, rem_e;
  logic            fix;

  // Estimate quotient, at most one short of the true value
  assign prod = PRW'(dividend_i) * PRW'(RECIP);

  // Correct the estimate
  assign qd    = EW'(q0_r) * DIV_E;
  assign rem_e = EW'(x_r) - qd;
  assign fix   = (rem_e >= DIV_E);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i) begin
      x_r  <= dividend_i;
      q0_r <= IN_W'(prod >> S);
    end
    if (v1_r) begin
      quot_r <= q0_r + IN_W'(fix);
      rem_r  <= RW'(fix ? (rem_e - DIV_E) : rem_e);
    end
  end

  assign valid_o = v2_r;
  assign quot_o  = quot_r;
  assign rem_o   = rem_r;

endmodule

@@ hw/rtl/sala_index.sv @@
// ----------------------------------------------------------------------------
// sala_index
// Address generation: forms the byte address, then derives the set number
// through a chain of constant dividers and the tag by a shift.
// ----------------------------------------------------------------------------
module sala_index #(
  parameter int LINE_BYTES = 64,
  parameter int TOTAL_SETS = 64,
  parameter int SETS_HERE  = 16,
  parameter int TAG_SHIFT  = 12,
  parameter int SET_W      = 4,
  parameter int TAG_W      = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  logic [sala_pkg::ADDR_W-1:0] base_i,
  input  logic [sala_pkg::ADDR_W-1:0] index_i,
  output logic                        valid_o,
  output logic [SET_W-1:0]            set_o,
  output logic [TAG_W-1:0]            tag_o
);

  localparam int AW      = sala_pkg::ADDR_W;
  localparam int Q1_W    = AW - ($clog2(LINE_BYTES + 1) - 1);
  localparam int MOD_W   = $clog2(TOTAL_SETS);
  localparam int DIV_RAW = TOTAL_SETS / SETS_HERE;
  localparam int DIV     = (DIV_RAW == 0) ? 1 : DIV_RAW;
  localparam int CMP_W   = ((MOD_W > SET_W) ? MOD_W : SET_W) + 1;
  localparam logic [CMP_W-1:0] SETS_C = CMP_W'(SETS_HERE);

  logic             va_r, vo_r;
  logic [AW-1:0]    addr_r;
  logic             v1, v2, v3;
  logic [AW-1:0]    q1;
  logic [Q1_W-1:0]  q2_unused_dummy;
  logic [MOD_W-1:0] r2, q3;
  logic [CMP_W-1:0] fold_in, fold;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;

  // Byte address, wrapping at the address width
  always_ff @(posedge clk) begin
    if (valid_i) begin
      addr_r <= base_i + {index_i[AW-3:0], 2'b00};
    end
  end

  // Line number
  sala_cdiv #(.IN_W(AW), .DIVISOR(LINE_BYTES)) u_div_line (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (va_r),
    .dividend_i (addr_r),
    .valid_o    (v1),
    .quot_o     (q1),
    .rem_o      ()
  );

  // Line number modulo the total set count
  sala_cdiv #(.IN_W(Q1_W), .DIVISOR(TOTAL_SETS)) u_div_sets (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (v1),
    .dividend_i (q1[Q1_W-1:0]),
    .valid_o    (v2),
    .quot_o     (q2_unused_dummy),
    .rem_o      (r2)
  );

  // Scale down to the sets of this bank
  sala_cdiv #(.IN_W(MOD_W), .DIVISOR(DIV)) u_div_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (v2),
    .dividend_i (r2),
    .valid_o    (v3),
    .quot_o     (q3),
    .rem_o      ()
  );

  // Scaled value stays below twice the bank's set count: one subtract folds it
  assign fold_in = CMP_W'(q3);
  assign fold    = (fold_in >= SETS_C) ? (fold_in - SETS_C) : fold_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      va_r <= valid_i;
      vo_r <= v3 & ~(|q2_unused_dummy & 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      set_r <= SET_W'(fold);
      tag_r <= addr_r[AW-1:TAG_SHIFT];
    end
  end

  assign valid_o = vo_r;
  assign set_o   = set_r;
  assign tag_o   = tag_r;

endmodule

@@ hw/rtl/sala_core.sv @@
// ----------------------------------------------------------------------------
// sala_core
// Tag/stamp memory and line memory with the read-modify-write sequencer:
// hit detection, LRU victim scan, fill, recency update and counters.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_read_cache_top_defines.svh"

module sala_core #(
  parameter int WAYS      = 16,
  parameter int SETS_HERE = 16,
  parameter int TAG_W     = 20,
  parameter int SET_W     = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                lookup_i,
  input  logic [SET_W-1:0]    set_i,
  input  logic [TAG_W-1:0]    tag_i,
  input  sala_pkg::cmd_t      cmd_i,
  output logic                res_valid_o,
  output sala_pkg::result_t   res_o,
  output logic                clearing_o
);

  localparam int SW      = sala_pkg::STAMP_W;
  localparam int CW      = sala_pkg::CNT_W;
  localparam int WAY_W   = $clog2(WAYS);
  localparam int META_W  = 1 + TAG_W + SW;
  localparam int V_BIT   = META_W - 1;
  localparam int ENTRIES = SETS_HERE * WAYS;
  localparam int LA_W    = $clog2(ENTRIES);
  localparam logic [SW-1:0] STAMP_ONE = SW'(1);
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);

  // Per set: valid, tag and recency stamp of every way
  logic [WAYS-1:0][META_W-1:0] meta_mem [SETS_HERE];
  logic [WAYS-1:0][META_W-1:0] meta_q_r, meta_wdata;
  logic                        meta_re, meta_we;
  logic [SET_W-1:0]            meta_wset;

  logic [sala_pkg::LINE_W-1:0] line_mem [ENTRIES];
  logic [sala_pkg::LINE_W-1:0] line_q_r;
  logic                        line_re, line_we;
  logic [WAY_W-1:0]            line_way;
  logic [LA_W-1:0]             line_addr;

  sala_pkg::core_state_t       state_r, state_nxt;
  logic [SET_W-1:0]            clr_set_r, clr_set_nxt;
  logic [SW-1:0]               stamp_r, stamp_nxt;
  logic [CW-1:0]               acc_r, acc_nxt, hit_cnt_r, hit_cnt_nxt;
  logic [SW-1:0]               min_stamp_r, min_stamp_nxt;
  logic [WAY_W-1:0]            victim_r, victim_nxt, scan_way_r, scan_way_nxt;
  sala_pkg::result_t           res_r, res_nxt;
  logic                        res_valid_r, respond;

  logic                        hit;
  logic [WAY_W-1:0]            hit_way;
  logic [SW-1:0]               cur_stamp;
  logic                        is_read;

  assign is_read = (cmd_i.req_type == sala_pkg::REQ_READ);

  // Tag compare on all ways; the highest matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (meta_q_r[w][V_BIT] && (meta_q_r[w][V_BIT-1:SW] == tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign cur_stamp = meta_q_r[scan_way_r][SW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sala_pkg::ST_CLEAR: begin
        if (clr_set_r == SET_W'(SETS_HERE - 1)) state_nxt = sala_pkg::ST_IDLE;
      end
      sala_pkg::ST_IDLE: begin
        if (lookup_i) state_nxt = sala_pkg::ST_EVAL;
      end
      sala_pkg::ST_EVAL: begin
        if (hit && is_read) state_nxt = sala_pkg::ST_LINE;
        else if (!hit && !is_read) state_nxt = sala_pkg::ST_SCAN;
        else state_nxt = sala_pkg::ST_IDLE;
      end
      sala_pkg::ST_LINE: state_nxt = sala_pkg::ST_IDLE;
      sala_pkg::ST_SCAN: begin
        if (scan_way_r == WAY_W'(WAYS - 1)) state_nxt = sala_pkg::ST_FILL;
      end
      sala_pkg::ST_FILL: state_nxt = sala_pkg::ST_IDLE;
      default: state_nxt = sala_pkg::ST_IDLE;
    endcase
  end

  // Memory controls, scan, counters and the result
  always_comb begin
    meta_re       = 1'b0;
    meta_we       = 1'b0;
    meta_wset     = set_i;
    meta_wdata    = meta_q_r;
    line_re       = 1'b0;
    line_we       = 1'b0;
    line_way      = hit_way;
    respond       = 1'b0;
    clr_set_nxt   = clr_set_r;
    acc_nxt       = acc_r;
    hit_cnt_nxt   = hit_cnt_r;
    min_stamp_nxt = min_stamp_r;
    victim_nxt    = victim_r;
    scan_way_nxt  = scan_way_r;
    res_nxt       = '0;
    res_nxt.outcome = sala_pkg::OUT_DONE;
    res_nxt.dest  = cmd_i.dest;
    res_nxt.idle  = 1'b1;
    unique case (state_r)
      sala_pkg::ST_CLEAR: begin
        meta_we     = 1'b1;
        meta_wset   = clr_set_r;
        meta_wdata  = '0;
        clr_set_nxt = clr_set_r + SET_W'(1);
      end
      sala_pkg::ST_IDLE: begin
        meta_re = lookup_i;
      end
      sala_pkg::ST_EVAL: begin
        if (hit) begin
          // refresh recency of the hit way
          meta_we = 1'b1;
          meta_wdata[hit_way][SW-1:0] = stamp_r;
          acc_nxt     = acc_r + CNT_ONE;
          hit_cnt_nxt = hit_cnt_r + CNT_ONE;
          if (is_read) begin
            line_re = 1'b1;
          end else begin
            respond = 1'b1;
          end
        end else if (is_read) begin
          respond         = 1'b1;
          res_nxt.outcome = sala_pkg::OUT_MISS;
          res_nxt.idle    = 1'b0;
        end else begin
          // start victim scan from way 0
          min_stamp_nxt = meta_q_r[0][SW-1:0];
          victim_nxt    = '0;
          scan_way_nxt  = WAY_W'(1);
        end
      end
      sala_pkg::ST_LINE: begin
        respond           = 1'b1;
        res_nxt.outcome   = sala_pkg::OUT_HIT;
        res_nxt.line_low  = line_q_r[sala_pkg::LOW_W-1:0];
        res_nxt.line_mid  = line_q_r[sala_pkg::LOW_W+sala_pkg::MID_W-1:sala_pkg::LOW_W];
        res_nxt.line_high = line_q_r[sala_pkg::LINE_W-1:sala_pkg::LOW_W+sala_pkg::MID_W];
      end
      sala_pkg::ST_SCAN: begin
        // strict compare keeps the lowest way on a tie
        if (cur_stamp < min_stamp_r) begin
          min_stamp_nxt = cur_stamp;
          victim_nxt    = scan_way_r;
        end
        scan_way_nxt = scan_way_r + WAY_W'(1);
      end
      sala_pkg::ST_FILL: begin
        meta_we              = 1'b1;
        meta_wdata[victim_r] = {1'b1, tag_i, stamp_r};
        line_we              = 1'b1;
        line_way             = victim_r;
        acc_nxt              = acc_r + CNT_ONE;
        respond              = 1'b1;
      end
      default: begin
        respond = 1'b0;
      end
    endcase
    res_nxt.access_total = acc_nxt;
    res_nxt.hit_total    = hit_cnt_nxt;
  end

  // One stamp step per completed transaction
  assign stamp_nxt = respond ? (stamp_r + STAMP_ONE) : stamp_r;

  assign line_addr = LA_W'(set_i) * LA_W'(WAYS) + LA_W'(line_way);

  // Tag/stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wset] <= meta_wdata;
    end
    if (meta_re) begin
      meta_q_r <= meta_mem[set_i];
    end
  end

  // Line memory
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_addr] <= {cmd_i.fill_high, cmd_i.fill_mid, cmd_i.fill_low};
    end
    if (line_re) begin
      line_q_r <= line_mem[line_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sala_pkg::ST_CLEAR;
      clr_set_r   <= '0;
      stamp_r     <= STAMP_ONE;
      acc_r       <= '0;
      hit_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_set_r   <= clr_set_nxt;
      stamp_r     <= stamp_nxt;
      acc_r       <= acc_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      res_valid_r <= respond;
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    min_stamp_r <= min_stamp_nxt;
    victim_r    <= victim_nxt;
    scan_way_r  <= scan_way_nxt;
    if (respond) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid_o = res_valid_r;
  assign res_o       = res_r;
  assign clearing_o  = (state_r == sala_pkg::ST_CLEAR);

  `SALA_ASSERT_SAME(a_lookup_when_idle, clk, rst_n, lookup_i, state_r == sala_pkg::ST_IDLE, "lookup while a transaction is in flight")
  `SALA_ASSERT_NEXT(a_lookup_to_eval, clk, rst_n, lookup_i, state_r == sala_pkg::ST_EVAL, "lookup did not reach evaluation")
  `SALA_ASSERT_SAME(a_result_idle, clk, rst_n, res_valid_r, state_r == sala_pkg::ST_IDLE, "result strobe outside idle")
  `SALA_ASSERT_SAME(a_stamp_step, clk, rst_n, res_valid_r, stamp_r == $past(stamp_r) + STAMP_ONE, "stamp did not advance with the result")

endmodule

@@ hw/rtl/set_assoc_lru_read_cache_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_read_cache_top
// One bank of a set-associative cache with LRU-stamp replacement and
// valid-marked tags, fed by a start/busy command port.
// ----------------------------------------------------------------------------
// One request at a time: start is taken when busy is low, and the result
// appears on the out_ ports for exactly one cycle with out_strobe high; it
// cannot be held off, so capture it then. busy falls in the strobe cycle, so
// the next request can be taken at the edge that ends it. From start to
// strobe a request passes the address divider chain and the read-modify-write
// of the set's tag/stamp row; a read hit adds a line memory read, and a fill
// that misses adds the LRU victim scan, which visits one way per cycle. After
// reset a clearing pass invalidates every set; busy stays high meanwhile. The
// base address register is written through cfg_ at any time but must only
// change while no request is in flight.
module set_assoc_lru_read_cache_top #(
  parameter int WAYS       = 16,
  parameter int LINE_BYTES = 64,
  parameter int TOTAL_SETS = 64,
  parameter int SETS_HERE  = 16,
  parameter int TAG_SHIFT  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command input
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [sala_pkg::ADDR_W-1:0]   in_element_index,
  input  logic [sala_pkg::DEST_W-1:0]   in_destination,
  input  logic [sala_pkg::LOW_W-1:0]    in_fill_low,
  input  logic [sala_pkg::MID_W-1:0]    in_fill_mid,
  input  logic [sala_pkg::HIGH_W-1:0]   in_fill_high,
  // result output
  output logic                          out_strobe,
  output logic [1:0]                    out_outcome,
  output logic [sala_pkg::DEST_W-1:0]   out_reply_destination,
  output logic [sala_pkg::LOW_W-1:0]    out_line_low,
  output logic [sala_pkg::MID_W-1:0]    out_line_mid,
  output logic [sala_pkg::HIGH_W-1:0]   out_line_high,
  output logic                          out_requester_idle,
  output logic [sala_pkg::CNT_W-1:0]    out_access_total,
  output logic [sala_pkg::CNT_W-1:0]    out_hit_total,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sala_pkg::ADDR_W-1:0]   cfg_base_address
);

  localparam int TAG_W = sala_pkg::ADDR_W - TAG_SHIFT;
  localparam int SET_W = (SETS_HERE > 1) ? $clog2(SETS_HERE) : 1;

  logic [sala_pkg::ADDR_W-1:0] base_r;
  logic                        busy_r;
  logic                        accept;
  sala_pkg::cmd_t              cmd_r;
  logic                        idx_valid;
  logic [SET_W-1:0]            idx_set;
  logic [TAG_W-1:0]            idx_tag;
  logic                        res_valid;
  sala_pkg::result_t           res;
  logic                        clearing;

  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign busy      = (busy_r & ~res_valid) | clearing;

  // Base address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_base_address;
    end
  end

  // Hold busy from acceptance to the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (res_valid) begin
      busy_r <= 1'b0;
    end
  end

  // Capture the command for the whole transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.req_type  <= sala_pkg::req_type_t'(in_req_type);
      cmd_r.dest      <= in_destination;
      cmd_r.fill_low  <= in_fill_low;
      cmd_r.fill_mid  <= in_fill_mid;
      cmd_r.fill_high <= in_fill_high;
    end
  end

  sala_index #(
    .LINE_BYTES (LINE_BYTES),
    .TOTAL_SETS (TOTAL_SETS),
    .SETS_HERE  (SETS_HERE),
    .TAG_SHIFT  (TAG_SHIFT),
    .SET_W      (SET_W),
    .TAG_W      (TAG_W)
  ) u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (accept),
    .base_i  (base_r),
    .index_i (in_element_index),
    .valid_o (idx_valid),
    .set_o   (idx_set),
    .tag_o   (idx_tag)
  );

  sala_core #(
    .WAYS      (WAYS),
    .SETS_HERE (SETS_HERE),
    .TAG_W     (TAG_W),
    .SET_W     (SET_W)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_i    (idx_valid),
    .set_i       (idx_set),
    .tag_i       (idx_tag),
    .cmd_i       (cmd_r),
    .res_valid_o (res_valid),
    .res_o       (res),
    .clearing_o  (clearing)
  );

  assign out_strobe            = res_valid;
  assign out_outcome           = res.outcome;
  assign out_reply_destination = res.dest;
  assign out_line_low          = res.line_low;
  assign out_line_mid          = res.line_mid;
  assign out_line_high         = res.line_high;
  assign out_requester_idle    = res.idle;
  assign out_access_total      = res.access_total;
  assign out_hit_total         = res.hit_total;

endmodule
